// ===== src/positional_list_engine_defines.svh =====
// Assertion macros for the positional list engine.
// Used by the top level only; expects i_clk and i_rst_n in scope.
`ifndef POSITIONAL_LIST_ENGINE_DEFINES_SVH
`define POSITIONAL_LIST_ENGINE_DEFINES_SVH

`ifndef SYNTH
// checked only outside reset
`define PLE_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("positional_list_engine: check failed");
// checked during reset too
`define PLE_ASSERT_RST(label, prop) \
    label: assert property (@(posedge i_clk) (prop)) \
        else $error("positional_list_engine: reset check failed");
`else
`define PLE_ASSERT(label, prop)
`define PLE_ASSERT_RST(label, prop)
`endif

`endif

// ===== src/ple_pkg.sv =====
// Shared constants and types for the positional list engine.
// No dependencies; used by ple_cell and positional_list_engine.
package ple_pkg;

    localparam int CAPACITY_DEF = 16;

    // item opcodes
    localparam logic [3:0] OP_INS_FRONT = 4'd0;
    localparam logic [3:0] OP_INS_BACK  = 4'd1;
    localparam logic [3:0] OP_INS_AT    = 4'd2;
    localparam logic [3:0] OP_DEL_FRONT = 4'd3;
    localparam logic [3:0] OP_DEL_BACK  = 4'd4;
    localparam logic [3:0] OP_DEL_AT    = 4'd5;
    localparam logic [3:0] OP_SEARCH    = 4'd6;
    localparam logic [3:0] OP_DUMP_FWD  = 4'd7;
    localparam logic [3:0] OP_DUMP_REV  = 4'd8;

    // result status
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_EMPTY    = 3'd1;
    localparam logic [2:0] ST_BADPOS   = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;

    // command broadcast to every cell of the chain
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_INS,
        CELL_DEL,
        CELL_ROTL,
        CELL_ROTR,
        CELL_CMP
    } t_cell_op;

endpackage

// ===== src/ple_cell.sv =====
// One storage cell of the list chain: holds one element and a match flag.
// Depends on ple_pkg (t_cell_op).
module ple_cell #(
    parameter int IDX = 0,
    parameter int LW  = 5
) (
    input  logic               i_clk,
    input  ple_pkg::t_cell_op  i_cmd,
    input  logic [LW-1:0]      i_idx,
    input  logic [LW-1:0]      i_len,
    input  logic [31:0]        i_key,
    input  logic [31:0]        i_left,
    input  logic [31:0]        i_right,
    input  logic [31:0]        i_head,
    input  logic [31:0]        i_tail,
    output logic [31:0]        o_value,
    output logic               o_match
);

    localparam logic [LW-1:0] MY_IDX  = LW'(IDX);
    localparam logic [LW-1:0] MY_POS1 = LW'(IDX + 1);

    logic [31:0] r_value;
    logic [31:0] n_value;
    logic        r_match;

    always_comb begin
        n_value = r_value;
        case (i_cmd)
            ple_pkg::CELL_INS: begin
                if (MY_IDX == i_idx) begin
                    n_value = i_key;
                end else if (MY_IDX > i_idx) begin
                    n_value = i_left;
                end
            end
            ple_pkg::CELL_DEL: begin
                if (MY_IDX >= i_idx) begin
                    n_value = i_right;
                end
            end
            ple_pkg::CELL_ROTL: begin
                // last occupied cell wraps around to the head
                if (MY_POS1 == i_len) begin
                    n_value = i_head;
                end else if (MY_POS1 < i_len) begin
                    n_value = i_right;
                end
            end
            ple_pkg::CELL_ROTR: begin
                if (IDX == 0) begin
                    n_value = i_tail;
                end else if (MY_IDX < i_len) begin
                    n_value = i_left;
                end
            end
            default: begin
                n_value = r_value;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        if (i_cmd == ple_pkg::CELL_CMP) begin
            r_match <= (r_value == i_key) && (MY_IDX < i_len);
        end
    end

    assign o_value = r_value;
    assign o_match = r_match;

endmodule

// ===== src/positional_list_engine.sv =====
// Positional list engine top level: control sequencer, output register, cell chain.
// Depends on ple_pkg, ple_cell and positional_list_engine_defines.svh.
//
// Usage: an ordered list of up to CAPACITY signed 32-bit values held in a
// chain of cells, cell 0 being the front. Input transfers (i_in_valid,
// o_in_stall) carry op, value and position; results leave through a single
// output register (o_out_valid, i_out_stall) with status, element,
// found_position and last.
// One item is worked at a time. An item is taken into the op, value and
// position registers and executed in S_EXEC once the output register is
// free; insert, delete and unknown ops put their result in the output
// register from S_EXEC. For a search the cells compare in parallel, then
// a priority encoder picks the first hit in S_SRCH. In a dump the chain
// rotates one step per result and is back in its original order at the end.
// o_in_stall is high while an item is being worked. When the receiver
// stalls, the result stays in the output register and the sequencer waits
// for it to drain before writing the next one.
// Reset empties the list and drops any pending result; cell contents are
// not cleared.
`include "positional_list_engine_defines.svh"

module positional_list_engine #(
    parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [3:0]         i_op,
    input  logic signed [31:0] i_value,
    input  logic [4:0]         i_position,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [2:0]         o_status,
    output logic signed [31:0] o_element,
    output logic [4:0]         o_found_position,
    output logic               o_last
);

    localparam int LW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);
    localparam int CW = ((LW > 5) ? LW : 5) + 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_SRCH = 2'd2;
    localparam logic [1:0] S_DUMP = 2'd3;

    logic [1:0]        r_state, n_state;
    logic [LW-1:0]     r_len, n_len;
    logic [LW-1:0]     r_cnt, n_cnt;
    logic [3:0]        r_op;
    logic [31:0]       r_value;
    logic [4:0]        r_pos;

    logic              r_out_valid;
    logic [2:0]        r_status;
    logic [31:0]       r_element;
    logic [4:0]        r_fpos;
    logic              r_last;

    logic              w_load;
    logic [2:0]        w_status;
    logic [31:0]       w_element;
    logic [4:0]        w_fpos;
    logic              w_last;
    logic              w_out_free;

    ple_pkg::t_cell_op w_cmd;
    logic [LW-1:0]     w_idx;
    logic [31:0]       w_val [CAPACITY];
    logic [CAPACITY-1:0] w_match;
    logic [31:0]       w_tail;
    logic [IW-1:0]     w_tail_idx;
    logic [IW-1:0]     w_first;
    logic              w_found;

    logic [CW-1:0]     w_pos_c;
    logic [CW-1:0]     w_len_c;
    logic              w_full;
    logic              w_empty;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_pos_c    = CW'(r_pos);
    assign w_len_c    = CW'(r_len);
    assign w_full     = (r_len == LW'(CAPACITY));
    assign w_empty    = (r_len == '0);
    assign w_tail_idx = IW'(r_len - 1'b1);
    assign w_tail     = w_val[w_tail_idx];

    // cell chain
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [31:0] w_left;
        logic [31:0] w_right;
        if (g == 0) begin : g_first
            assign w_left = w_val[0];
        end else begin : g_mid
            assign w_left = w_val[g-1];
        end
        if (g == CAPACITY - 1) begin : g_end
            assign w_right = w_val[g];
        end else begin : g_inner
            assign w_right = w_val[g+1];
        end
        ple_cell #(
            .IDX (g),
            .LW  (LW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (w_cmd),
            .i_idx   (w_idx),
            .i_len   (r_len),
            .i_key   (r_value),
            .i_left  (w_left),
            .i_right (w_right),
            .i_head  (w_val[0]),
            .i_tail  (w_tail),
            .o_value (w_val[g]),
            .o_match (w_match[g])
        );
    end

    // first matching cell
    always_comb begin
        w_found = 1'b0;
        w_first = '0;
        for (int k = CAPACITY - 1; k >= 0; k--) begin
            if (w_match[k]) begin
                w_found = 1'b1;
                w_first = IW'(k);
            end
        end
    end

    always_comb begin
        n_state   = r_state;
        n_len     = r_len;
        n_cnt     = r_cnt;
        w_cmd     = ple_pkg::CELL_HOLD;
        w_idx     = '0;
        w_load    = 1'b0;
        w_status  = ple_pkg::ST_OK;
        w_element = '0;
        w_fpos    = '0;
        w_last    = 1'b1;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_out_free) begin
                    case (r_op)
                        ple_pkg::OP_INS_FRONT, ple_pkg::OP_INS_BACK, ple_pkg::OP_INS_AT: begin
                            w_load  = 1'b1;
                            n_state = S_IDLE;
                            if (w_full) begin
                                w_status = ple_pkg::ST_FULL;
                            end else if (r_op == ple_pkg::OP_INS_AT &&
                                         (w_pos_c == '0 || w_pos_c > w_len_c + 1'b1)) begin
                                w_status = ple_pkg::ST_BADPOS;
                            end else begin
                                w_cmd = ple_pkg::CELL_INS;
                                n_len = r_len + 1'b1;
                                if (r_op == ple_pkg::OP_INS_BACK) begin
                                    w_idx = r_len;
                                end else if (r_op == ple_pkg::OP_INS_AT) begin
                                    w_idx = LW'(w_pos_c - 1'b1);
                                end
                            end
                        end
                        ple_pkg::OP_DEL_FRONT, ple_pkg::OP_DEL_BACK, ple_pkg::OP_DEL_AT: begin
                            w_load  = 1'b1;
                            n_state = S_IDLE;
                            if (w_empty) begin
                                w_status = ple_pkg::ST_EMPTY;
                            end else if (r_op == ple_pkg::OP_DEL_AT &&
                                         (w_pos_c == '0 || w_pos_c > w_len_c)) begin
                                w_status = ple_pkg::ST_BADPOS;
                            end else begin
                                w_cmd = ple_pkg::CELL_DEL;
                                n_len = r_len - 1'b1;
                                if (r_op == ple_pkg::OP_DEL_BACK) begin
                                    w_idx = r_len - 1'b1;
                                end else if (r_op == ple_pkg::OP_DEL_AT) begin
                                    w_idx = LW'(w_pos_c - 1'b1);
                                end
                            end
                        end
                        ple_pkg::OP_SEARCH: begin
                            w_cmd   = ple_pkg::CELL_CMP;
                            n_state = S_SRCH;
                        end
                        ple_pkg::OP_DUMP_FWD, ple_pkg::OP_DUMP_REV: begin
                            if (w_empty) begin
                                w_load   = 1'b1;
                                w_status = ple_pkg::ST_EMPTY;
                                n_state  = S_IDLE;
                            end else begin
                                n_cnt   = r_len;
                                n_state = S_DUMP;
                            end
                        end
                        default: begin
                            w_load   = 1'b1;
                            w_status = ple_pkg::ST_BADPOS;
                            n_state  = S_IDLE;
                        end
                    endcase
                end
            end
            S_SRCH: begin
                if (w_out_free) begin
                    w_load  = 1'b1;
                    n_state = S_IDLE;
                    if (w_found) begin
                        w_fpos = 5'({1'b0, w_first} + 1'b1);
                    end else begin
                        w_status = ple_pkg::ST_NOTFOUND;
                    end
                end
            end
            S_DUMP: begin
                if (w_out_free) begin
                    w_load = 1'b1;
                    w_last = (r_cnt == LW'(1));
                    n_cnt  = r_cnt - 1'b1;
                    // rotate so the next element to send sits at the same end
                    if (r_op == ple_pkg::OP_DUMP_FWD) begin
                        w_element = w_val[0];
                        w_cmd     = ple_pkg::CELL_ROTL;
                    end else begin
                        w_element = w_tail;
                        w_cmd     = ple_pkg::CELL_ROTR;
                    end
                    if (w_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
            r_cnt   <= n_cnt;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) begin
            r_op    <= i_op;
            r_value <= i_value;
            r_pos   <= i_position;
        end
        if (w_load) begin
            r_status  <= w_status;
            r_element <= w_element;
            r_fpos    <= w_fpos;
            r_last    <= w_last;
        end
    end

    assign o_in_stall       = (r_state != S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_status         = r_status;
    assign o_element        = r_element;
    assign o_found_position = r_fpos;
    assign o_last           = r_last;

    `PLE_ASSERT(a_len_bound, r_len <= LW'(CAPACITY))
    `PLE_ASSERT(a_take_to_exec, (i_in_valid && !o_in_stall) |=> (r_state == S_EXEC))
    `PLE_ASSERT(a_dump_keeps_len, (r_state == S_DUMP) |=> (r_len == $past(r_len)))
    `PLE_ASSERT_RST(a_reset_empty, !i_rst_n |=> (r_len == '0 && !o_out_valid))

endmodule
